>>> sv/tgen_pkg.sv
// Shared types and constants of the tone generator.
// Holds the register index codes, fixed widths and the sine table entry function.
// No dependencies.
package tgen_pkg;

   typedef enum logic [1:0] {
      CSR_PHASE_STEP     = 2'd0,
      CSR_PLAY_LEVEL     = 2'd1,
      CSR_RAMP_STEP      = 2'd2,
      CSR_LATENCY_FRAMES = 2'd3
   } csr_index_type;

   localparam int CSR_DATA_W  = 32;
   localparam int GAIN_W      = 16;
   localparam int PEAK_PORT_W = 16;
   localparam int HEARD_PORT_W = 48;
   localparam int REQ_DATA_W  = 8;

   localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd32768;

   localparam logic [31:0] PHASE_STEP_RST     = 32'd19685266;
   localparam logic [15:0] PLAY_LEVEL_RST     = 16'd8192;
   localparam logic [15:0] RAMP_STEP_RST      = 16'd137;
   localparam logic [31:0] LATENCY_FRAMES_RST = 32'd0;

   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam longint signed   ONE_Q30 = 64'sd1073741824;
   localparam longint unsigned SERIES_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                   64'd110, 64'd156};

   // quarter-wave entry: sin(pi/2 * (i + 0.5) / 2^index_bits) scaled to full scale
   function automatic logic [31:0] sine_entry(int unsigned index, int unsigned index_bits,
                                              int unsigned sample_bits);
      longint unsigned theta;
      longint unsigned x2;
      longint unsigned term;
      longint signed   sum;
      longint unsigned amp;
      longint unsigned s;
      theta = ((2 * longint'(index) + 1) * PI_Q30) >> (index_bits + 2);
      x2    = (theta * theta) >> 30;
      term  = theta;
      sum   = longint'(theta);
      for (int k = 0; k < 6; k++) begin
         term = (term * x2) >> 30;
         term = term / SERIES_DIV[k];
         if (k % 2 == 0) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > ONE_Q30) begin
         sum = ONE_Q30;
      end
      amp = (64'd1 << (sample_bits - 1)) - 64'd1;
      s   = longint'(sum);
      return 32'((s * amp + (64'd1 << 29)) >> 30);
   endfunction

endpackage

>>> sv/tgen_sine_rom.sv
// Quarter-wave sine ROM with registered read.
// Contents are built at elaboration from tgen_pkg::sine_entry.
// Depends on tgen_pkg.
module tgen_sine_rom #(
   parameter int INDEX_BITS  = 10,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [INDEX_BITS-1:0]  rd_addr,
   output logic [SAMPLE_BITS-2:0] rd_data
);
   import tgen_pkg::*;

   localparam int DEPTH   = 1 << INDEX_BITS;
   localparam int ENTRY_W = SAMPLE_BITS - 1;

   typedef logic [ENTRY_W-1:0] rom_type [DEPTH];

   function automatic rom_type build_rom();
      rom_type r;
      for (int i = 0; i < DEPTH; i++) begin
         r[i] = ENTRY_W'(sine_entry(i, INDEX_BITS, SAMPLE_BITS));
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= SINE_ROM[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tone_generator_gain_ramp_peak.sv
// Tone generator top level: phase accumulator, slew-limited gain, peak meter, heard position.
// Depends on tgen_pkg and tgen_sine_rom.
//
//   channel   dir   handshake              payload
//   req_*     in    tvalid/tready          tdata: play_request, peak_clear; tlast: block_end
//   rsp_*     out   tvalid/tready          tdata: sample_out, peak_level, heard_frames
//   csr_*     in    we (no wait)           index, wdata
//
// One item per cycle sustained while rsp_tready stays high; rsp_tvalid rises once its item has passed the stages below.
// The three stages are the sine ROM read, the gain multiply, and the output register.
// Synchronous active-high reset restores register defaults and empties the pipeline.
// The sine ROM is constant, so no clearing pass follows reset.
// With rsp_tready low the pipeline fills; req_tready drops once three items wait.
module tone_generator_gain_ramp_peak #(
   parameter int PHASE_BITS       = 32,
   parameter int TABLE_INDEX_BITS = 10,
   parameter int SAMPLE_BITS      = 16,
   parameter int FRAME_BITS       = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tgen_pkg::REQ_DATA_W-1:0]     req_tdata,  // [0] play_request, [1] peak_clear
   input  logic                                req_tlast,  // block_end
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // sample_out, peak_level (16), heard_frames (48), zero fill to bytes
   output logic [((SAMPLE_BITS+64+7)/8)*8-1:0] rsp_tdata,
   input  logic                                csr_we,
   input  tgen_pkg::csr_index_type             csr_index,
   input  logic [tgen_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tgen_pkg::*;

   localparam int ENTRY_W   = SAMPLE_BITS - 1;
   localparam int PROD_W    = ENTRY_W + GAIN_W;
   localparam int PH_EXT_W  = (PHASE_BITS > 32) ? PHASE_BITS : 32;
   localparam int PEAK_EXT_W = (ENTRY_W > PEAK_PORT_W) ? ENTRY_W : PEAK_PORT_W;
   localparam int HEARD_EXT_W = (FRAME_BITS > HEARD_PORT_W) ? FRAME_BITS : HEARD_PORT_W;
   localparam int RSP_W     = ((SAMPLE_BITS + PEAK_PORT_W + HEARD_PORT_W + 7) / 8) * 8;

   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << 14;

   logic [31:0] phase_step_ff;
   logic [15:0] play_level_ff;
   logic [15:0] ramp_step_ff;
   logic [31:0] latency_ff;

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic                  latched_ff;
   logic [FRAME_BITS-1:0] frames_ff, frames_in;
   logic [ENTRY_W-1:0]    peak_ff;

   logic                  s1_valid_ff;
   logic [GAIN_W-1:0]     s1_gain_ff;
   logic                  s1_neg_ff;
   logic [FRAME_BITS-1:0] s1_frames_ff;
   logic                  s1_clear_ff;

   logic                  s2_valid_ff;
   logic [ENTRY_W-1:0]    s2_mag_ff;
   logic                  s2_neg_ff;
   logic [FRAME_BITS-1:0] s2_heard_ff;
   logic                  s2_clear_ff;

   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic [ENTRY_W-1:0]     rsp_peak_ff;
   logic [FRAME_BITS-1:0]  rsp_heard_ff;

   logic adv1, adv2, adv3, req_fire;

   logic [GAIN_W-1:0]           target, step, diff, delta;
   logic [1:0]                  quad;
   logic [TABLE_INDEX_BITS-1:0] idx, rom_addr;
   logic [ENTRY_W-1:0]          rom_data;
   logic [PH_EXT_W-1:0]         phase_sum;
   logic [PROD_W-1:0]           prod_sum;
   logic [FRAME_BITS-1:0]       latency_ext, heard_in;
   logic [SAMPLE_BITS-1:0]      mag_ext, sample_in;
   logic [ENTRY_W-1:0]          peak_max;
   logic [PEAK_EXT_W-1:0]       peak_ext;
   logic [HEARD_EXT_W-1:0]      heard_ext;

   assign adv3       = !rsp_valid_ff || rsp_tready;
   assign adv2       = !s2_valid_ff || adv3;
   assign adv1       = !s1_valid_ff || adv2;
   assign req_tready = adv1;
   assign req_fire   = req_tvalid && adv1;

   // gain slew, sine table addressing and per-item state advance
   always_comb begin
      target = '0;
      if (latched_ff) begin
         target = (play_level_ff > UNITY_GAIN) ? UNITY_GAIN : play_level_ff;
      end
      step = (ramp_step_ff > UNITY_GAIN) ? UNITY_GAIN : ramp_step_ff;
      if (target > gain_ff) begin
         diff    = target - gain_ff;
         delta   = (diff > step) ? step : diff;
         gain_in = gain_ff + delta;
      end else begin
         diff    = gain_ff - target;
         delta   = (diff > step) ? step : diff;
         gain_in = gain_ff - delta;
      end

      quad     = phase_ff[PHASE_BITS-1 -: 2];
      idx      = phase_ff[PHASE_BITS-3 -: TABLE_INDEX_BITS];
      rom_addr = quad[0] ? ~idx : idx;

      phase_sum = PH_EXT_W'(phase_ff) + PH_EXT_W'(phase_step_ff);
      phase_in  = phase_sum[PHASE_BITS-1:0];

      frames_in = frames_ff;
      if (latched_ff && (frames_ff != '1)) begin
         frames_in = frames_ff + FRAME_BITS'(1);
      end
   end

   tgen_sine_rom #(
      .INDEX_BITS  (TABLE_INDEX_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   always_comb begin
      prod_sum    = PROD_W'(s1_gain_ff) * PROD_W'(rom_data) + ROUND_HALF;
      latency_ext = FRAME_BITS'(latency_ff);
      heard_in    = (s1_frames_ff > latency_ext) ? (s1_frames_ff - latency_ext) : '0;
      mag_ext     = SAMPLE_BITS'(s2_mag_ff);
      sample_in   = s2_neg_ff ? (SAMPLE_BITS'(0) - mag_ext) : mag_ext;
      peak_max    = (s2_mag_ff > peak_ff) ? s2_mag_ff : peak_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= PHASE_STEP_RST;
         play_level_ff <= PLAY_LEVEL_RST;
         ramp_step_ff  <= RAMP_STEP_RST;
         latency_ff    <= LATENCY_FRAMES_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PHASE_STEP:     phase_step_ff <= csr_wdata;
            CSR_PLAY_LEVEL:     play_level_ff <= csr_wdata[15:0];
            CSR_RAMP_STEP:      ramp_step_ff  <= csr_wdata[15:0];
            CSR_LATENCY_FRAMES: latency_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         gain_ff      <= '0;
         latched_ff   <= 1'b0;
         frames_ff    <= '0;
         peak_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff  <= phase_in;
            gain_ff   <= gain_in;
            frames_ff <= frames_in;
            if (req_tlast) begin
               latched_ff <= req_tdata[0];
            end
         end
         if (adv1) begin
            s1_valid_ff <= req_fire;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            rsp_valid_ff <= s2_valid_ff;
            if (s2_valid_ff) begin
               peak_ff <= s2_clear_ff ? '0 : peak_max;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_gain_ff   <= gain_in;
         s1_neg_ff    <= quad[1];
         s1_frames_ff <= frames_in;
         s1_clear_ff  <= req_tdata[1];
      end
      if (adv2 && s1_valid_ff) begin
         s2_mag_ff   <= prod_sum[15 +: ENTRY_W];
         s2_neg_ff   <= s1_neg_ff;
         s2_heard_ff <= heard_in;
         s2_clear_ff <= s1_clear_ff;
      end
      if (adv3 && s2_valid_ff) begin
         rsp_sample_ff <= sample_in;
         rsp_peak_ff   <= peak_max;
         rsp_heard_ff  <= s2_heard_ff;
      end
   end

   assign peak_ext   = PEAK_EXT_W'(rsp_peak_ff);
   assign heard_ext  = HEARD_EXT_W'(rsp_heard_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({heard_ext[HEARD_PORT_W-1:0], peak_ext[PEAK_PORT_W-1:0],
                               rsp_sample_ff});

   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= UNITY_GAIN)
      else $error("gain above unity");

   a_frames_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !latched_ff) |=> $stable(frames_ff))
      else $error("frame count moved while not playing");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !s2_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !adv3) |=> (s2_valid_ff && $stable(s2_mag_ff)))
      else $error("stalled multiply stage lost its item");

endmodule
